// ===== rtl/sia_pkg.sv =====
// shared constants, types and state encoding for the decimal text converter
package sia_pkg;

  localparam int VALUE_W    = 32;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int CHAR_W     = 8;
  localparam int STEP_CNT_W = $clog2(VALUE_W);
  localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);

  localparam logic [CHAR_W-1:0]     CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]     CHAR_MINUS = 8'd45;
  localparam logic [DIGIT_W-1:0]    DAB_THRESH = 4'd5;
  localparam logic [DIGIT_W-1:0]    DAB_ADJ    = 4'd3;
  localparam logic [STEP_CNT_W-1:0] LAST_STEP  = STEP_CNT_W'(VALUE_W - 1);
  localparam logic [DIG_IDX_W-1:0]  LAST_DIGIT = DIG_IDX_W'(NUM_DIGITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } sia_state_t;

  // controls from the sequencer to the shift-add-3 unit
  typedef struct packed {
    logic load;
    logic step;
    logic shift;
  } sia_dab_ctl_t;

endpackage

// ===== rtl/sia_in_if.sv =====
// input channel: one signed number per transfer
interface sia_in_if import sia_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/sia_out_if.sv =====
// result channel: one character code per transfer
interface sia_out_if import sia_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== rtl/sia_dabble.sv =====
// bit-serial binary to bcd shift register (shift-add-3) with digit unload
module sia_dabble import sia_pkg::*; (
  input  logic                clk,
  input  sia_dab_ctl_t        ctl,
  input  logic [VALUE_W-1:0]  mag,
  output logic [DIGIT_W-1:0]  top_digit
);

  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [BCD_W-1:0]   bcd_adj;

  // per-digit correction, digits are independent
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      logic [DIGIT_W-1:0] dig;
      dig = bcd_r[i*DIGIT_W +: DIGIT_W];
      bcd_adj[i*DIGIT_W +: DIGIT_W] = (dig >= DAB_THRESH) ? dig + DAB_ADJ : dig;
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (ctl.load) begin
      bin_nxt = mag;
      bcd_nxt = '0;
    end else if (ctl.step) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
      bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
    end else if (ctl.shift) begin
      bcd_nxt = {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// top level: signed 32-bit number to ascii decimal character stream
//
//   channel   dir   payload                      meaning
//   in_ch     in    value[31:0] signed           number to convert
//   out_ch    out   char_code[7:0], last_char    one character of its text
//
// one number at a time: it is taken in idle, then converted in 32 bit-serial
// shift-add-3 steps; a minus sign goes out first when it is negative, leading
// zeros are then skipped one at a time (at most 9), and the characters are sent
// one per transfer when out_ch is ready (1 to 11); skipped zeros and digits always add up to 10 positions
// reset is synchronous, active low, and returns the sequencer to idle
// a stall on out_ch holds the current character; no new number is taken
// until the last character of the current one has been transferred
module signed_int_to_decimal_ascii import sia_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sia_in_if.sink     in_ch,
  sia_out_if.source  out_ch
);

  sia_state_t              state_r, state_nxt;
  logic [STEP_CNT_W-1:0]   step_r, step_nxt;   // conversion step counter
  logic [DIG_IDX_W-1:0]    idx_r, idx_nxt;     // digit position, msd first
  logic                    neg_r, neg_nxt;

  logic                    in_xfer, out_xfer;
  logic [VALUE_W-1:0]      raw, mag;
  logic [DIGIT_W-1:0]      top_digit;
  logic                    top_zero, at_last;
  sia_dab_ctl_t            dab_ctl;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;

  // magnitude as unsigned, so the most negative value maps to 2^31
  assign raw = in_ch.value;
  assign mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;

  assign top_zero = (top_digit == '0);
  assign at_last  = (idx_r == LAST_DIGIT);

  sia_dabble u_dabble (
    .clk       (clk),
    .ctl       (dab_ctl),
    .mag       (mag),
    .top_digit (top_digit)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    neg_nxt   = neg_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_CONV;
          step_nxt  = '0;
          neg_nxt   = raw[VALUE_W-1];
        end
      end
      ST_CONV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = neg_r ? ST_SIGN : ST_SKIP;
          idx_nxt   = '0;
        end
      end
      ST_SIGN: begin
        if (out_xfer) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, but always keep the units digit
        if (top_zero && !at_last) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_xfer) begin
          if (at_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    in_ch.ready      = 1'b0;
    out_ch.valid     = 1'b0;
    out_ch.char_code = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
    out_ch.last_char = 1'b0;
    dab_ctl          = '0;
    dab_ctl.load     = in_xfer;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_CONV: begin
        dab_ctl.step = 1'b1;
      end
      ST_SIGN: begin
        out_ch.valid     = 1'b1;
        out_ch.char_code = CHAR_MINUS;
      end
      ST_SKIP: begin
        dab_ctl.shift = top_zero && !at_last;
      end
      ST_EMIT: begin
        out_ch.valid     = 1'b1;
        out_ch.last_char = at_last;
        dab_ctl.shift    = out_xfer && !at_last;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      idx_r   <= '0;
      neg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      idx_r   <= idx_nxt;
      neg_r   <= neg_nxt;
    end
  end

endmodule

// ===== rtl/sia_checker.sv =====
// port-level assertions for the decimal text converter, bound to the top level
module sia_checker import sia_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_char_code,
  input logic              out_last_char
);

  // one number at a time: never taking input while text is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a character is offered");

  // a new number closes the input once it has been taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a transfer");

  // only minus or decimal digits appear
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == CHAR_MINUS ||
                   (out_char_code >= CHAR_ZERO && out_char_code <= CHAR_ZERO + 8'd9)))
    else $error("character code out of set");

  // minus sign is always followed by digits
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_char_code == CHAR_MINUS) |-> !out_last_char)
    else $error("minus sign marked last");

  // run ends cleanly after its last character
  a_end_of_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_char) |=> !out_valid)
    else $error("character offered after end of run");

endmodule

bind signed_int_to_decimal_ascii sia_checker u_sia_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_char_code (out_ch.char_code),
  .out_last_char (out_ch.last_char)
);
